FILE: hdl/sdhr_pkg.sv
package sdhr_pkg;

   // item opcodes
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // report kinds
   localparam logic KIND_JOYSTICK = 1'b0;
   localparam logic KIND_MOUSE    = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_LOCKOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_KNOB_PERIOD   = 2'd1;
   localparam logic [1:0] CSR_MOUSE_MODE    = 2'd2;

   // configuration reset values
   localparam logic [7:0] LOCKOUT_TICKS_RST = 8'd10;
   localparam logic [6:0] KNOB_PERIOD_RST   = 7'd96;
   localparam logic       MOUSE_MODE_RST    = 1'b0;

   // width of switch_bits and button_mask
   localparam int unsigned MASK_W = 8;

   typedef struct packed {
      logic              opcode;
      logic [7:0]        switch_bits;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
   } req_item_type;

   typedef struct packed {
      logic              send;
      logic              report_kind;
      logic signed [7:0] axis_x;
      logic signed [7:0] axis_y;
      logic [7:0]        button_mask;
   } rsp_item_type;

   // what one switch lane tells the merge logic
   typedef struct packed {
      logic level;
      logic take;
   } lane_status_type;

   // controls broadcast to every switch lane
   typedef struct packed {
      logic       tick;
      logic       commit;
      logic [7:0] lockout_ticks;
   } lane_ctrl_type;

endpackage

FILE: hdl/sdhr_switch_lane.sv
module sdhr_switch_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  sdhr_pkg::lane_ctrl_type  ctrl,
   input  logic                     raw,
   output sdhr_pkg::lane_status_type status
);
   import sdhr_pkg::*;

   logic       level_ff, level_in;
   logic       reported_ff, reported_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] count_loaded;
   logic       take;

   // a free switch takes a new level when it differs from the reported one
   assign take = ctrl.tick && (count_ff == 8'd0) && (raw != reported_ff);

   always_comb begin
      level_in     = take ? raw : level_ff;
      count_loaded = take ? ctrl.lockout_ticks : count_ff;
      count_in     = count_ff;
      if (ctrl.tick) begin
         // count down every nonzero counter, including one just loaded
         count_in = (count_loaded != 8'd0) ? count_loaded - 8'd1 : 8'd0;
      end
      reported_in = ctrl.commit ? level_ff : reported_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= 1'b0;
         reported_ff <= 1'b0;
         count_ff    <= 8'd0;
      end else begin
         level_ff    <= level_in;
         reported_ff <= reported_in;
         count_ff    <= count_in;
      end
   end

   assign status.level = level_ff;
   assign status.take  = take;

endmodule

FILE: hdl/sdhr_knob_axis.sv
module sdhr_knob_axis (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic signed [7:0] delta,
   input  logic [6:0]        period,
   output logic signed [7:0] pos_next
);
   import sdhr_pkg::*;

   logic signed [7:0] pos_ff;
   logic signed [7:0] pos_in;
   logic signed [9:0] sum;
   logic signed [9:0] per;
   logic signed [9:0] wrapped;

   // position plus delta, corrected once into the period
   always_comb begin
      sum = {{2{pos_ff[7]}}, pos_ff} + {{2{delta[7]}}, delta};
      per = $signed({3'b000, period});
      if (sum < 10'sd0) begin
         wrapped = sum + per;
      end else if (sum >= per) begin
         wrapped = sum - per;
      end else begin
         wrapped = sum;
      end
      pos_next = wrapped[7:0];
      pos_in   = advance ? pos_next : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 8'sd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: hdl/switch_debounce_hid_report_core.sv
// Lockout switch debounce with joystick/mouse report builder. Takes one item
// per clock: a frame tick (switch levels) or a report request (knob deltas).
// Each switch has its own lane with a lockout counter; a merge step gathers
// the debounced levels into the button mask and tracks the changed flag, and
// two knob units wrap the joystick positions once by the knob period. Every
// request yields exactly one result in the cycle after acceptance, held in a
// single output register; ticks give no result. An item of either kind
// stalls only while that register holds a result not yet taken.
// Configuration is written through csr_we/csr_index/csr_wdata while idle;
// index 3 is ignored.
module switch_debounce_hid_report_core #(
   parameter int unsigned NUM_SWITCHES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sdhr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sdhr_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_wdata
);
   import sdhr_pkg::*;

   // configuration registers
   logic [7:0] lockout_ticks_ff;
   logic [6:0] knob_period_ff;
   logic       mouse_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_TICKS_RST;
         knob_period_ff   <= KNOB_PERIOD_RST;
         mouse_mode_ff    <= MOUSE_MODE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOCKOUT_TICKS: lockout_ticks_ff <= csr_wdata;
            CSR_KNOB_PERIOD:   knob_period_ff   <= csr_wdata[6:0];
            CSR_MOUSE_MODE:    mouse_mode_ff    <= csr_wdata[0];
            default:           ;
         endcase
      end
   end

   // handshake
   logic         req_fire;
   logic         tick_fire;
   logic         report_fire;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_fire    = req_valid && req_ready;
   assign tick_fire   = req_fire && (req_item.opcode == OP_TICK);
   assign report_fire = req_fire && (req_item.opcode == OP_REPORT);

   // request decode
   logic motion;
   logic changed_ff, changed_in;
   logic joy_send;
   logic commit;

   assign motion   = (req_item.delta_x != 8'sd0) || (req_item.delta_y != 8'sd0);
   assign joy_send = motion || changed_ff;
   assign commit   = report_fire && !mouse_mode_ff && joy_send;

   // switch lanes
   lane_ctrl_type             lane_ctrl;
   lane_status_type           lane_st [NUM_SWITCHES];
   logic [NUM_SWITCHES-1:0]   take_vec;
   logic [MASK_W-1:0]         button_mask;

   assign lane_ctrl.tick          = tick_fire;
   assign lane_ctrl.commit        = commit;
   assign lane_ctrl.lockout_ticks = lockout_ticks_ff;

   for (genvar i = 0; i < NUM_SWITCHES; i++) begin : g_lane
      logic raw;
      if (i < MASK_W) begin : g_pin
         assign raw = req_item.switch_bits[i];
      end else begin : g_nopin
         assign raw = 1'b0;
      end
      sdhr_switch_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (lane_ctrl),
         .raw    (raw),
         .status (lane_st[i])
      );
      assign take_vec[i] = lane_st[i].take;
   end

   // merge: button mask from lane levels
   for (genvar b = 0; b < MASK_W; b++) begin : g_mask
      if (b < NUM_SWITCHES) begin : g_used
         assign button_mask[b] = lane_st[b].level;
      end else begin : g_unused
         assign button_mask[b] = 1'b0;
      end
   end

   // changed flag: set by any lane take, cleared by a sent joystick report
   always_comb begin
      changed_in = changed_ff;
      if (tick_fire && (|take_vec)) begin
         changed_in = 1'b1;
      end else if (commit) begin
         changed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         changed_ff <= 1'b1;
      end else begin
         changed_ff <= changed_in;
      end
   end

   // knob positions
   logic signed [7:0] pos_x_next;
   logic signed [7:0] pos_y_next;

   sdhr_knob_axis u_knob_x (
      .clock    (clock),
      .reset    (reset),
      .advance  (commit),
      .delta    (req_item.delta_x),
      .period   (knob_period_ff),
      .pos_next (pos_x_next)
   );

   sdhr_knob_axis u_knob_y (
      .clock    (clock),
      .reset    (reset),
      .advance  (commit),
      .delta    (req_item.delta_y),
      .period   (knob_period_ff),
      .pos_next (pos_y_next)
   );

   // result formation
   always_comb begin
      rsp_item_in = '0;
      if (mouse_mode_ff) begin
         if (motion) begin
            rsp_item_in.send        = 1'b1;
            rsp_item_in.report_kind = KIND_MOUSE;
            rsp_item_in.axis_x      = req_item.delta_x;
            rsp_item_in.axis_y      = req_item.delta_y;
         end
      end else if (joy_send) begin
         rsp_item_in.send        = 1'b1;
         rsp_item_in.report_kind = KIND_JOYSTICK;
         rsp_item_in.axis_x      = pos_x_next;
         rsp_item_in.axis_y      = pos_y_next;
         rsp_item_in.button_mask = button_mask;
      end
   end

   // output register
   always_comb begin
      if (report_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (report_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      commit |=> !changed_ff)
      else $error("changed flag not cleared after joystick report");

   a_take_sets: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && (|take_vec)) |=> changed_ff)
      else $error("changed flag not set after switch change");

   a_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      (tick_fire && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("tick produced a result");

   a_nosend_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.send) |-> (rsp_item_ff == '0))
      else $error("no-send result carries nonzero fields");

endmodule
